// ===== src/tla_pkg.sv =====
// Shared types and constants for the light selection block.
package tla_pkg;

    localparam int RESULT_CAP  = 16;
    localparam int IDX_FIELD_W = 6;

    typedef struct packed {
        logic [15:0] level;
        logic [15:0] atten_q;
        logic [15:0] atten_l;
        logic [15:0] atten_c;
        logic [31:0] pos_z;
        logic [31:0] pos_y;
        logic [31:0] pos_x;
    } light_t;

    typedef struct packed {
        logic                   valid;
        logic [IDX_FIELD_W-1:0] index;
        logic [31:0]            power;
    } cell_t;

endpackage

// ===== src/tla_power.sv =====
// Sequential power unit: distance squares, square root, denominator and division.
module tla_power
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  tla_pkg::light_t light,
    input  logic [31:0]     qx,
    input  logic [31:0]     qy,
    input  logic [31:0]     qz,
    output logic            done,
    output logic [31:0]     power
);

    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_SQ   = 6'b000010,
        ST_ROOT = 6'b000100,
        ST_TERM = 6'b001000,
        ST_DIV  = 6'b010000,
        ST_DONE = 6'b100000
    } pw_state_t;

    pw_state_t   state_reg, state_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic [31:0] mag_reg [0:2];
    logic [31:0] mag_next [0:2];
    logic [15:0] c_reg, l_reg, q_reg, lvl_reg;
    logic [63:0] prod_reg, prod_next;
    logic [63:0] d2_reg, d2_next;
    logic [63:0] rad_reg, rad_next;
    logic [32:0] rem_reg, rem_next;
    logic [31:0] root_reg, root_next;
    logic [63:0] den_reg, den_next;
    logic [31:0] num_reg, num_next;
    logic [31:0] quo_reg, quo_next;
    logic [63:0] drem_reg, drem_next;
    logic [31:0] power_reg, power_next;
    logic [31:0] mul_a, mul_b;
    logic [64:0] sum65;
    logic [34:0] rem_t, trial;
    logic [64:0] div_t;

    function automatic logic [31:0] abs_diff(input logic [31:0] a, input logic [31:0] b);
        logic signed [32:0] d;
        d = $signed({a[31], a}) - $signed({b[31], b});
        abs_diff = d[32] ? 32'(-d) : d[31:0];
    endfunction

    always_comb
    begin
        case (state_reg)
            ST_SQ:
            begin
                case (cnt_reg)
                    5'd0:    mul_a = mag_reg[0];
                    5'd1:    mul_a = mag_reg[1];
                    5'd2:    mul_a = mag_reg[2];
                    default: mul_a = 32'd0;
                endcase
                mul_b = mul_a;
            end
            ST_TERM:
            begin
                case (cnt_reg)
                    5'd0:
                    begin
                        mul_a = root_reg;
                        mul_b = {16'd0, l_reg};
                    end
                    5'd1:
                    begin
                        mul_a = d2_reg[63:32];
                        mul_b = {16'd0, q_reg};
                    end
                    5'd2:
                    begin
                        mul_a = d2_reg[31:0];
                        mul_b = {16'd0, q_reg};
                    end
                    default:
                    begin
                        mul_a = 32'd0;
                        mul_b = 32'd0;
                    end
                endcase
            end
            default:
            begin
                mul_a = 32'd0;
                mul_b = 32'd0;
            end
        endcase
    end

    assign sum65 = {1'b0, d2_reg} + {1'b0, prod_reg};
    assign rem_t = {rem_reg, rad_reg[63:62]};
    assign trial = {1'b0, root_reg, 2'b01};
    assign div_t = {drem_reg, num_reg[31]};

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        mag_next   = mag_reg;
        prod_next  = {32'd0, mul_a} * {32'd0, mul_b};
        d2_next    = d2_reg;
        rad_next   = rad_reg;
        rem_next   = rem_reg;
        root_next  = root_reg;
        den_next   = den_reg;
        num_next   = num_reg;
        quo_next   = quo_reg;
        drem_next  = drem_reg;
        power_next = power_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    mag_next[0] = abs_diff(light.pos_x, qx);
                    mag_next[1] = abs_diff(light.pos_y, qy);
                    mag_next[2] = abs_diff(light.pos_z, qz);
                    d2_next     = 64'd0;
                    cnt_next    = 5'd0;
                    state_next  = ST_SQ;
                end
            end
            ST_SQ:
            begin
                if (cnt_reg != 5'd0)
                begin
                    d2_next = sum65[64] ? {64{1'b1}} : sum65[63:0];
                end
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == 5'd3)
                begin
                    rad_next   = d2_next;
                    rem_next   = 33'd0;
                    root_next  = 32'd0;
                    cnt_next   = 5'd0;
                    state_next = ST_ROOT;
                end
            end
            ST_ROOT:
            begin
                if (rem_t >= trial)
                begin
                    rem_next  = 33'(rem_t - trial);
                    root_next = {root_reg[30:0], 1'b1};
                end
                else
                begin
                    rem_next  = rem_t[32:0];
                    root_next = {root_reg[30:0], 1'b0};
                end
                rad_next = {rad_reg[61:0], 2'b00};
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == 5'd31)
                begin
                    den_next   = {40'd0, c_reg, 8'd0};
                    cnt_next   = 5'd0;
                    state_next = ST_TERM;
                end
            end
            ST_TERM:
            begin
                case (cnt_reg)
                    5'd1:    den_next = den_reg + (prod_reg >> 8);
                    5'd2:    den_next = den_reg + (prod_reg << 8);
                    5'd3:    den_next = den_reg + (prod_reg >> 24);
                    default: den_next = den_reg;
                endcase
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == 5'd3)
                begin
                    num_next   = {lvl_reg, 16'd0};
                    drem_next  = 64'd0;
                    quo_next   = 32'd0;
                    cnt_next   = 5'd0;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (div_t >= {1'b0, den_reg})
                begin
                    drem_next = 64'(div_t - {1'b0, den_reg});
                    quo_next  = {quo_reg[30:0], 1'b1};
                end
                else
                begin
                    drem_next = div_t[63:0];
                    quo_next  = {quo_reg[30:0], 1'b0};
                end
                num_next = {num_reg[30:0], 1'b0};
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == 5'd31)
                begin
                    power_next = (den_reg == 64'd0) ? {32{1'b1}} : quo_next;
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= 5'd0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mag_reg   <= mag_next;
        prod_reg  <= prod_next;
        d2_reg    <= d2_next;
        rad_reg   <= rad_next;
        rem_reg   <= rem_next;
        root_reg  <= root_next;
        den_reg   <= den_next;
        num_reg   <= num_next;
        quo_reg   <= quo_next;
        drem_reg  <= drem_next;
        power_reg <= power_next;
        if (state_reg == ST_IDLE && start)
        begin
            c_reg   <= light.atten_c;
            l_reg   <= light.atten_l;
            q_reg   <= light.atten_q;
            lvl_reg <= light.level;
        end
    end

    assign done  = (state_reg == ST_DONE);
    assign power = power_reg;

endmodule

// ===== src/tla_cell.sv =====
// One cell of the insertion chain, kept sorted by power or in arrival order.
module tla_cell
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           clear,
    input  logic           ins_en,
    input  logic           order_mode,
    input  tla_pkg::cell_t ins,
    input  logic           left_beats,
    input  tla_pkg::cell_t left,
    input  logic           shift_en,
    input  tla_pkg::cell_t right,
    output logic           beats,
    output tla_pkg::cell_t cur
);

    logic                            valid_reg;
    logic [tla_pkg::IDX_FIELD_W-1:0] index_reg;
    logic [31:0]                     power_reg;
    tla_pkg::cell_t                  cur_next;

    assign cur   = {valid_reg, index_reg, power_reg};
    assign beats = !valid_reg || (!order_mode && (ins.power > power_reg));

    always_comb
    begin
        cur_next = cur;
        if (clear)
        begin
            cur_next.valid = 1'b0;
        end
        else if (ins_en)
        begin
            if (beats)
            begin
                cur_next = left_beats ? left : ins;
            end
        end
        else if (shift_en)
        begin
            cur_next = right;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= cur_next.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        index_reg <= cur_next.index;
        power_reg <= cur_next.power;
    end

endmodule

// ===== src/top_lights_by_attenuation.sv =====
// Top level: light store, power unit, selection chain and stream ports.
//
//  port group   dir   accepted when            payload
//  s_*          in    s_tvalid && s_tready     s_tdata fields, s_tuser = action
//  m_*          out   m_tvalid && m_tready     m_tdata fields, m_tlast = last
//  p*           cfg   psel&penable&pwrite      light_count when paddr[2] is 0
//
// A query computes the power of each light in use in turn with the bit-serial
// square root and divider of the shared power unit, then the results shift out
// of the chain. Reset clears control and valid bits only. s_tready is low from a
// query's acceptance until its results have left the chain; m_tready low holds
// the output item and the chain.
module top_lights_by_attenuation
#(
    parameter int STORE_DEPTH = 16,
    parameter int TOP_COUNT   = 8
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready,
    input  logic         s_tvalid,
    output logic         s_tready,
    // light_slot[3:0], pos_x[35:4], pos_y[67:36], pos_z[99:68], atten_constant[115:100],
    // atten_linear[131:116], atten_quadratic[147:132], intensity[163:148], zero pad
    input  logic [167:0] s_tdata,
    // action[0]
    input  logic [0:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // light_index[3:0], power[35:4], zero pad
    output logic [39:0]  m_tdata,
    output logic         m_tlast
);

    localparam int IDX_W = $clog2(STORE_DEPTH);
    localparam int CNT_W = $clog2(STORE_DEPTH + 1);
    localparam int NW    = (CNT_W > 5) ? CNT_W : 5;
    localparam int KEEP  = (TOP_COUNT < tla_pkg::RESULT_CAP) ? TOP_COUNT : tla_pkg::RESULT_CAP;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_READ  = 5'b00010,
        S_START = 5'b00100,
        S_WAIT  = 5'b01000,
        S_DRAIN = 5'b10000
    } state_t;

    state_t          state_reg, state_next;
    logic [4:0]      count_reg;
    logic [CNT_W-1:0] n_reg, n_next;
    logic [CNT_W-1:0] slot_reg, slot_next;
    logic            order_reg, order_next;
    logic [31:0]     qx_reg, qy_reg, qz_reg;
    tla_pkg::light_t mem [0:STORE_DEPTH-1];
    tla_pkg::light_t rd_reg;
    tla_pkg::light_t wr_light;
    logic            in_acc, is_load, is_query, we;
    logic [NW-1:0]   n_calc;
    logic            pw_start;
    logic            pw_done;
    logic [31:0]     pw_power;
    logic            clear, ins_en, shift_en;
    tla_pkg::cell_t  ins;
    tla_pkg::cell_t  cells [0:KEEP];
    logic            beats [0:KEEP-1];
    logic            out_valid_reg;
    logic [3:0]      out_idx_reg;
    logic [31:0]     out_pow_reg;
    logic            out_last_reg;
    logic            out_free;

    assign pready = 1'b1;
    assign prdata = {27'd0, count_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= 5'd0;
        end
        else if (psel && penable && pwrite && paddr[2] == 1'b0)
        begin
            count_reg <= pwdata[4:0];
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign in_acc   = s_tvalid && s_tready;
    assign is_load  = in_acc && !s_tuser[0];
    assign is_query = in_acc && s_tuser[0];
    assign we       = is_load && (32'(s_tdata[3:0]) < STORE_DEPTH);

    assign wr_light.pos_x   = s_tdata[35:4];
    assign wr_light.pos_y   = s_tdata[67:36];
    assign wr_light.pos_z   = s_tdata[99:68];
    assign wr_light.atten_c = s_tdata[115:100];
    assign wr_light.atten_l = s_tdata[131:116];
    assign wr_light.atten_q = s_tdata[147:132];
    assign wr_light.level   = s_tdata[163:148];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[IDX_W'(s_tdata[3:0])] <= wr_light;
        end
        rd_reg <= mem[slot_reg[IDX_W-1:0]];
    end

    assign n_calc = (NW'(count_reg) > NW'(STORE_DEPTH)) ? NW'(STORE_DEPTH) : NW'(count_reg);

    always_comb
    begin
        state_next = state_reg;
        slot_next  = slot_reg;
        n_next     = n_reg;
        order_next = order_reg;
        clear      = 1'b0;
        ins_en     = 1'b0;
        pw_start   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (is_query)
                begin
                    clear      = 1'b1;
                    slot_next  = '0;
                    n_next     = CNT_W'(n_calc);
                    order_next = (32'(n_calc) <= TOP_COUNT);
                    if (n_calc != '0)
                    begin
                        state_next = S_READ;
                    end
                end
            end
            S_READ:
            begin
                state_next = S_START;
            end
            S_START:
            begin
                pw_start   = 1'b1;
                state_next = S_WAIT;
            end
            S_WAIT:
            begin
                if (pw_done)
                begin
                    ins_en    = 1'b1;
                    slot_next = slot_reg + CNT_W'(1);
                    state_next = (slot_next == n_reg) ? S_DRAIN : S_READ;
                end
            end
            S_DRAIN:
            begin
                if (!cells[0].valid)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            slot_reg  <= '0;
            n_reg     <= '0;
            order_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            slot_reg  <= slot_next;
            n_reg     <= n_next;
            order_reg <= order_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (is_query)
        begin
            qx_reg <= s_tdata[35:4];
            qy_reg <= s_tdata[67:36];
            qz_reg <= s_tdata[99:68];
        end
    end

    tla_power u_power
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (pw_start),
        .light (rd_reg),
        .qx    (qx_reg),
        .qy    (qy_reg),
        .qz    (qz_reg),
        .done  (pw_done),
        .power (pw_power)
    );

    assign ins.valid = 1'b1;
    assign ins.index = tla_pkg::IDX_FIELD_W'(slot_reg);
    assign ins.power = pw_power;

    assign out_free = !out_valid_reg || m_tready;
    assign shift_en = (state_reg == S_DRAIN) && cells[0].valid && out_free;
    assign cells[KEEP] = '0;

    for (genvar i = 0; i < KEEP; i++)
    begin : g_chain
        if (i == 0)
        begin : g_head
            tla_cell u_cell
            (
                .clk        (clk),
                .rst_n      (rst_n),
                .clear      (clear),
                .ins_en     (ins_en),
                .order_mode (order_reg),
                .ins        (ins),
                .left_beats (1'b0),
                .left       (ins),
                .shift_en   (shift_en),
                .right      (cells[i+1]),
                .beats      (beats[i]),
                .cur        (cells[i])
            );
        end
        else
        begin : g_body
            tla_cell u_cell
            (
                .clk        (clk),
                .rst_n      (rst_n),
                .clear      (clear),
                .ins_en     (ins_en),
                .order_mode (order_reg),
                .ins        (ins),
                .left_beats (beats[i-1]),
                .left       (cells[i-1]),
                .shift_en   (shift_en),
                .right      (cells[i+1]),
                .beats      (beats[i]),
                .cur        (cells[i])
            );
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (shift_en)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (shift_en)
        begin
            out_idx_reg  <= cells[0].index[3:0];
            out_pow_reg  <= cells[0].power;
            out_last_reg <= !cells[1].valid;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'd0, out_pow_reg, out_idx_reg};
    assign m_tlast  = out_last_reg;

endmodule

// ===== tb/tb.sv =====
// Testbench for top_lights_by_attenuation: directed and random loads and queries, scoreboarded.
module tb;

    localparam int SLOTS     = 16;
    localparam int TOP_N     = 8;
    localparam int LIMIT     = 1500000;
    localparam bit ACT_LOAD  = 1'b0;
    localparam bit ACT_QUERY = 1'b1;
    localparam bit [2:0] ADDR_LIGHT_COUNT = 3'd0;

    typedef struct {
        bit        action;
        bit [3:0]  slot;
        bit [31:0] x, y, z;
        bit [15:0] c, l, q, level;
    } light_item_t;

    typedef struct {
        bit [3:0]  index;
        bit [31:0] power;
        bit        last;
    } pick_t;

    class light_scoreboard;
        bit [31:0] sx[SLOTS], sy[SLOTS], sz[SLOTS];
        bit [15:0] sc[SLOTS], sl[SLOTS], sq[SLOTS], slev[SLOTS];
        bit [4:0]  count;
        pick_t     picks[$];

        function bit [63:0] axis_sq(bit [31:0] a, bit [31:0] b);
            longint diff;
            bit [63:0] mag;
            diff = longint'($signed(a)) - longint'($signed(b));
            mag  = (diff < 0) ? -diff : diff;
            return mag * mag;
        endfunction

        function bit [63:0] add_sat(bit [63:0] a, bit [63:0] b);
            bit [64:0] s;
            s = {1'b0, a} + {1'b0, b};
            return s[64] ? '1 : s[63:0];
        endfunction

        function bit [31:0] root(bit [63:0] v);
            bit [63:0] res, one;
            res = 0;
            one = 64'd1 << 62;
            while (one > v)
                one = one >> 2;
            while (one != 0)
            begin
                if (v >= res + one)
                begin
                    v   = v - (res + one);
                    res = (res >> 1) + one;
                end
                else
                    res = res >> 1;
                one = one >> 2;
            end
            return res[31:0];
        endfunction

        function bit [31:0] attenuated(int s, light_item_t it);
            bit [63:0] d2, d, qterm, den, p;
            d2 = axis_sq(sx[s], it.x);
            d2 = add_sat(d2, axis_sq(sy[s], it.y));
            d2 = add_sat(d2, axis_sq(sz[s], it.z));
            d = root(d2);
            qterm = (((d2 >> 32) * sq[s]) << 8) + (((d2 & 64'hFFFF_FFFF) * sq[s]) >> 24);
            den = (64'(sc[s]) << 8) + ((d * sl[s]) >> 8) + qterm;
            if (den == 0)
                return '1;
            p = (64'(slev[s]) << 16) / den;
            return (p > 64'hFFFF_FFFF) ? '1 : p[31:0];
        endfunction

        function void note(light_item_t it);
            bit [31:0] pw[SLOTS];
            bit taken[SLOTS];
            int n, emit, pick;
            bit found;
            pick_t r;
            if (it.action == ACT_LOAD)
            begin
                sx[it.slot] = it.x; sy[it.slot] = it.y; sz[it.slot] = it.z;
                sc[it.slot] = it.c; sl[it.slot] = it.l; sq[it.slot] = it.q;
                slev[it.slot] = it.level;
                return;
            end
            n = (count > SLOTS) ? SLOTS : count;
            for (int s = 0; s < n; s++)
            begin
                pw[s] = attenuated(s, it);
                taken[s] = 0;
            end
            emit = (n <= TOP_N) ? n : TOP_N;
            for (int k = 0; k < emit; k++)
            begin
                pick = k;
                if (n > TOP_N)
                begin
                    found = 0;
                    for (int s = 0; s < n; s++)
                        if (!taken[s] && (!found || pw[s] > pw[pick]))
                        begin
                            pick = s;
                            found = 1;
                        end
                    taken[pick] = 1;
                end
                r.index = 4'(pick);
                r.power = pw[pick];
                r.last  = (k + 1 == emit);
                picks.insert(picks.size(), r);
            end
        endfunction

        function string check(bit [3:0] index, bit [31:0] power, bit last);
            pick_t e;
            if (picks.size() == 0)
                return $sformatf("unexpected result index %0d power %h", index, power);
            e = picks.pop_front();
            if (e.index != index || e.power != power || e.last != last)
                return $sformatf("got index %0d power %h last %0d, want %0d %h %0d",
                                 index, power, last, e.index, e.power, e.last);
            return "";
        endfunction
    endclass

    logic         clk = 0;
    logic         rst_n = 0;
    logic         psel = 0, penable = 0, pwrite = 0;
    logic [2:0]   paddr = 0;
    logic [31:0]  pwdata = 0;
    logic [31:0]  prdata;
    logic         pready;
    logic         s_tvalid = 0;
    logic         s_tready;
    // light_slot, pos_x, pos_y, pos_z, atten_constant, atten_linear, atten_quadratic, intensity
    logic [167:0] s_tdata = 0;
    // action
    logic [0:0]   s_tuser = 0;
    logic         m_tvalid;
    logic         m_tready = 0;
    // light_index, power
    logic [39:0]  m_tdata;
    logic         m_tlast;

    light_scoreboard sb = new();
    int  errors = 0;
    int  cycles = 0;
    int  hold_left = 0;
    bit  steady = 0;

    top_lights_by_attenuation dut (.*);

    always
    begin
        #4 clk = 1;
        #4 clk = 0;
    end

    task automatic report(string msg);
        $display("mismatch: %s", msg);
        errors++;
    endtask

    always @(posedge clk)
    begin
        string msg;
        cycles++;
        if (cycles > LIMIT)
        begin
            $display("FAIL top_lights_by_attenuation");
            $finish;
        end
        if (rst_n && m_tvalid && m_tready)
        begin
            msg = sb.check(m_tdata[3:0], m_tdata[35:4], m_tlast);
            if (msg != "")
                report(msg);
        end
        if (hold_left > 0)
        begin
            hold_left--;
            m_tready <= 0;
        end
        else
            m_tready <= steady || ($urandom_range(99) >= 6);
    end

    task automatic write_count(bit [31:0] v);
        @(posedge clk);
        psel <= 1; pwrite <= 1; penable <= 0; paddr <= ADDR_LIGHT_COUNT; pwdata <= v;
        @(posedge clk);
        penable <= 1;
        @(posedge clk);
        psel <= 0; penable <= 0; pwrite <= 0;
        sb.count = v[4:0];
    endtask

    task automatic send(light_item_t it);
        if (!steady && $urandom_range(99) < 6)
        begin
            s_tvalid <= 0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        s_tvalid <= 1;
        s_tuser  <= it.action;
        s_tdata  <= {4'b0, it.level, it.q, it.l, it.c, it.z, it.y, it.x, it.slot};
        do @(posedge clk); while (!s_tready);
        sb.note(it);
    endtask

    task automatic settle();
        s_tvalid <= 0;
        while (sb.picks.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    function automatic light_item_t make_load(int slot, bit [31:0] x, bit [31:0] y, bit [31:0] z,
                                              bit [15:0] c, bit [15:0] l, bit [15:0] q,
                                              bit [15:0] lev);
        light_item_t it;
        it.action = ACT_LOAD; it.slot = 4'(slot); it.x = x; it.y = y; it.z = z;
        it.c = c; it.l = l; it.q = q; it.level = lev;
        return it;
    endfunction

    function automatic light_item_t make_query(bit [31:0] x, bit [31:0] y, bit [31:0] z);
        light_item_t it;
        it = make_load($urandom_range(15), x, y, z, 16'($urandom), 16'($urandom),
                       16'($urandom), 16'($urandom));
        it.action = ACT_QUERY;
        return it;
    endfunction

    function automatic bit [31:0] rand_pos();
        if ($urandom_range(1))
            return $urandom;
        return $urandom_range(32'h8_0000) - 32'h4_0000;
    endfunction

    function automatic bit [15:0] rand_coef();
        case ($urandom_range(3))
            0: return '0;
            1: return 16'($urandom);
            default: return 16'($urandom_range(16'h200));
        endcase
    endfunction

    initial
    begin
        int settings[$] = '{31, 16, 9, 12, 5, 1, 0, 8, 16};
        light_item_t it;
        repeat (9) @(posedge clk);
        rst_n <= 1;

        // directed: empty query, fill every slot, then corner queries
        send(make_query(0, 0, 0));
        send(make_load(0, 0, 0, 0, 0, 0, 0, 16'hFFFF));
        send(make_load(1, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                       16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
        send(make_load(2, 32'h1_0000, 0, 0, 16'h100, 16'h100, 16'h100, 16'h8000));
        send(make_load(3, 32'h1_0000, 0, 0, 16'h100, 16'h100, 16'h100, 16'h8000));
        for (int s = 4; s < SLOTS; s++)
            send(make_load(s, rand_pos(), rand_pos(), rand_pos(),
                           rand_coef(), rand_coef(), rand_coef(), 16'($urandom)));
        settle();
        write_count(16);
        send(make_query(0, 0, 0));
        send(make_query(32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
        send(make_query(32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h0001_0000));
        settle();
        write_count(8);
        send(make_query(32'h1_0000, 0, 0));
        settle();
        write_count(4);
        send(make_query(0, 0, 0));
        settle();

        foreach (settings[i])
        begin
            write_count(settings[i]);
            steady = (i == 3);
            if (i == 1)
                hold_left = 4000;
            repeat (16)
            begin
                if ($urandom_range(99) < 60)
                    it = make_load($urandom_range(15), rand_pos(), rand_pos(), rand_pos(),
                                   rand_coef(), rand_coef(), rand_coef(), 16'($urandom));
                else
                    it = make_query(rand_pos(), rand_pos(), rand_pos());
                send(it);
            end
            settle();
        end
        steady = 0;

        s_tvalid <= 0;
        while (sb.picks.size() != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
        if (errors == 0)
            $display("PASS top_lights_by_attenuation");
        else
            $display("FAIL top_lights_by_attenuation");
        $finish;
    end
endmodule
